// ===== rtl/core/gated_root_counter_timers_macros.svh =====
// assertion macros for the gated root counter timer block
// used by the top level only, no other dependencies
`ifndef GATED_ROOT_COUNTER_TIMERS_MACROS_SVH
`define GATED_ROOT_COUNTER_TIMERS_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("grc assertion failed");

// next-cycle implication, disabled while in reset
`define GRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("grc assertion failed");

`endif

// ===== rtl/core/grc_pkg.sv =====
// shared types and constants for the gated root counter timers
// no dependencies
package grc_pkg;

    localparam int NUM_COUNTERS = 3;

    localparam int ACT_W   = 3;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 16;
    localparam int MODE_W  = 13;
    localparam int PRE_W   = 12;
    localparam int PIX_W   = 4;
    localparam int HS_W    = 12;
    localparam int IRQ_W   = 3;
    localparam int CFG_A_W = 1;
    localparam int CFG_D_W = 12;

    typedef logic [ACT_W-1:0]   t_action;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [PRE_W-1:0]   t_pre;
    typedef logic [PIX_W-1:0]   t_pix_div;
    typedef logic [HS_W-1:0]    t_hs_div;
    typedef logic [IRQ_W-1:0]   t_irq;
    typedef logic [CFG_A_W-1:0] t_cfg_addr;
    typedef logic [CFG_D_W-1:0] t_cfg_data;

    // actions
    localparam t_action ACT_TICK        = 3'd0;
    localparam t_action ACT_WR_COUNT    = 3'd1;
    localparam t_action ACT_WR_MODE     = 3'd2;
    localparam t_action ACT_WR_TARGET   = 3'd3;
    localparam t_action ACT_RD_COUNT    = 3'd4;
    localparam t_action ACT_RD_MODE     = 3'd5;
    localparam t_action ACT_BLANK_START = 3'd6;
    localparam t_action ACT_BLANK_END   = 3'd7;

    // configuration register indexes
    localparam t_cfg_addr CFG_PIX_DIV = 1'd0;
    localparam t_cfg_addr CFG_HS_DIV  = 1'd1;

    localparam t_pix_div PIX_DIV_RST = 4'd2;
    localparam t_hs_div  HS_DIV_RST  = 12'd1076;

    // mode bit positions
    localparam int MB_GATE_EN  = 0;
    localparam int MB_GM_LO    = 1;
    localparam int MB_GM_HI    = 2;
    localparam int MB_RST_TGT  = 3;
    localparam int MB_IRQ_TGT  = 4;
    localparam int MB_IRQ_OVF  = 5;
    localparam int MB_REPEAT   = 6;
    localparam int MB_TOGGLE   = 7;
    localparam int MB_CLK_SRC  = 8;
    localparam int MB_DIV8     = 9;
    localparam int MB_IRQ_LINE = 10;
    localparam int MB_TGT_FLAG = 11;
    localparam int MB_OVF_FLAG = 12;
    localparam int MB_WR_TOP   = 9;

    // gate modes
    localparam logic [1:0] GM_0 = 2'd0;
    localparam logic [1:0] GM_1 = 2'd1;
    localparam logic [1:0] GM_2 = 2'd2;
    localparam logic [1:0] GM_3 = 2'd3;

    // counter with the fixed divide-by-8 option and no gate
    localparam t_idx CNT_SYS = 2'd2;
    localparam t_pix_div CNT_PIX = 4'd0;
    localparam t_pre DIV8 = 12'd8;

    typedef struct packed {
        t_action action;
        t_idx    counter_index;
        t_data   write_value;
    } t_grc_item;

    // per-counter command for the current beat
    typedef struct packed {
        logic    tick;
        logic    sel;
        t_action action;
        t_data   value;
    } t_grc_cmd;

endpackage

// ===== rtl/core/grc_if.sv =====
// channel interfaces for the gated root counter timers
// depends on grc_pkg
interface grc_in_if;
    import grc_pkg::*;
    logic    valid;
    logic    ready;
    t_action action;
    t_idx    counter_index;
    t_data   write_value;
    modport source (output valid, action, counter_index, write_value, input ready);
    modport sink (input valid, action, counter_index, write_value, output ready);
endinterface

interface grc_out_if;
    import grc_pkg::*;
    logic  valid;
    logic  ready;
    t_data read_data;
    t_irq  irq_request;
    modport source (output valid, read_data, irq_request, input ready);
    modport sink (input valid, read_data, irq_request, output ready);
endinterface

interface grc_cfg_if;
    import grc_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_addr index;
    t_cfg_data data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/grc_timer.sv =====
// one 16-bit root counter: prescaler, count, target, mode and gate handling
// depends on grc_pkg
module grc_timer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  grc_pkg::t_grc_cmd  i_cmd,
    input  grc_pkg::t_idx      i_idx,
    input  grc_pkg::t_pix_div  i_pix_div,
    input  grc_pkg::t_hs_div   i_hs_div,
    output grc_pkg::t_data     o_count,
    output grc_pkg::t_mode     o_mode,
    output logic               o_irq
);
    import grc_pkg::*;

    t_data r_count,  n_count;
    t_data r_target, n_target;
    t_mode r_mode,   n_mode;
    t_pre  r_pre,    n_pre;
    logic  r_running, n_running;
    logic  r_spent,   n_spent;

    t_pre       w_div_raw;
    t_pre       w_div;
    t_pre       w_pre;
    t_data      w_cnt;
    t_mode      w_m;
    logic       w_ovf;
    logic       w_match;
    logic       w_tgt;
    logic       w_irq;
    logic       w_gateable;
    logic       w_gated;
    logic [1:0] w_gm;

    always_comb begin
        w_div_raw = t_pre'(1);
        if (i_idx == CNT_SYS) begin
            if (r_mode[MB_DIV8]) begin
                w_div_raw = DIV8;
            end
        end else if (r_mode[MB_CLK_SRC]) begin
            w_div_raw = (i_idx == t_idx'(CNT_PIX)) ? t_pre'(i_pix_div) : i_hs_div;
        end
        // a zero divisor counts every tick
        w_div = (w_div_raw == '0) ? t_pre'(1) : w_div_raw;
    end

    assign w_gateable = (i_idx != CNT_SYS);
    assign w_gated    = w_gateable && r_mode[MB_GATE_EN];
    assign w_gm       = r_mode[MB_GM_HI:MB_GM_LO];

    always_comb begin
        n_count   = r_count;
        n_target  = r_target;
        n_mode    = r_mode;
        n_pre     = r_pre;
        n_running = r_running;
        n_spent   = r_spent;
        w_pre     = r_pre + t_pre'(1);
        w_cnt     = r_count + t_data'(1);
        w_m       = r_mode;
        w_ovf     = 1'b0;
        w_match   = 1'b0;
        w_tgt     = 1'b0;
        w_irq     = 1'b0;
        if (i_cmd.tick) begin
            if (r_running) begin
                if (w_pre < w_div) begin
                    n_pre = w_pre;
                end else begin
                    n_pre   = '0;
                    w_ovf   = (w_cnt == '0) && r_mode[MB_IRQ_OVF];
                    w_match = (w_cnt == r_target);
                    w_tgt   = w_match && !r_spent && r_mode[MB_IRQ_TGT];
                    if (w_ovf) begin
                        w_m[MB_OVF_FLAG] = 1'b1;
                    end
                    if (w_tgt) begin
                        w_m[MB_TGT_FLAG] = 1'b1;
                    end
                    n_count = (w_match && r_mode[MB_RST_TGT]) ? '0 : w_cnt;
                    // repeat with reset-on-target keeps the target armed
                    if (w_match && !(r_mode[MB_RST_TGT] && r_mode[MB_REPEAT])) begin
                        n_spent = 1'b1;
                    end
                    w_irq = w_ovf || w_tgt;
                    if (w_irq && r_mode[MB_TOGGLE]) begin
                        w_m[MB_IRQ_LINE] = 1'b0;
                    end
                    n_mode = w_m;
                end
            end
        end else if (i_cmd.sel) begin
            unique case (i_cmd.action)
                ACT_TICK: begin
                end
                ACT_WR_COUNT: begin
                    n_count = i_cmd.value;
                    n_pre   = '0;
                    n_spent = 1'b0;
                end
                ACT_WR_MODE: begin
                    n_mode                  = '0;
                    n_mode[MB_WR_TOP:0]     = i_cmd.value[MB_WR_TOP:0];
                    n_mode[MB_IRQ_LINE]     = 1'b1;
                    n_count                 = '0;
                    n_pre                   = '0;
                    n_spent                 = 1'b0;
                    n_running = !(w_gateable && i_cmd.value[MB_GATE_EN]);
                end
                ACT_WR_TARGET: begin
                    n_target = i_cmd.value;
                    if (r_count >= i_cmd.value) begin
                        n_spent = 1'b1;
                    end
                end
                ACT_RD_COUNT: begin
                end
                ACT_RD_MODE: begin
                    n_mode[MB_TGT_FLAG] = 1'b0;
                    n_mode[MB_OVF_FLAG] = 1'b0;
                    n_mode[MB_IRQ_LINE] = 1'b1;
                end
                ACT_BLANK_START: begin
                    if (w_gated) begin
                        if (w_gm == GM_0) begin
                            n_running = 1'b0;
                        end else if (w_gm == GM_2) begin
                            n_running = 1'b1;
                            n_count   = '0;
                            n_pre     = '0;
                            n_spent   = 1'b0;
                        end
                    end
                end
                ACT_BLANK_END: begin
                    if (w_gated) begin
                        if (w_gm == GM_2) begin
                            n_running = 1'b0;
                        end else if (w_gm != GM_3 || !r_running) begin
                            n_running = 1'b1;
                            n_count   = '0;
                            n_pre     = '0;
                            n_spent   = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_target  <= '0;
            r_mode    <= '0;
            r_pre     <= '0;
            r_running <= 1'b1;
            r_spent   <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_target  <= n_target;
            r_mode    <= n_mode;
            r_pre     <= n_pre;
            r_running <= n_running;
            r_spent   <= n_spent;
        end
    end

    assign o_count = r_count;
    assign o_mode  = r_mode;
    assign o_irq   = w_irq;

endmodule

// ===== rtl/core/gated_root_counter_timers.sv =====
// top level of the gated root counter timers: input register, counters, result register
// depends on grc_pkg, grc_if, grc_timer and the assertion macro header
`include "gated_root_counter_timers_macros.svh"

// Three 16-bit root counters driven by a stream of action beats on i_in
// (tick, count/mode/target write, count/mode read, blank start/end gate event).
// Every input beat yields exactly one result beat on o_out carrying read_data
// (count or mode for reads, zero otherwise) and irq_request (one bit per
// counter that fired on a tick). i_cfg writes the pixel clock divisor (index 0)
// and the hsync divisor (index 1); it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Path: a beat is captured in the input register, the counters work on it
// when it advances and the result register loads from it at the same edge,
// so o_out.valid rises once the beat has moved from the input register into
// the result register.
// Throughput: one beat per cycle while o_out accepts, as the counters update
// from the input register into the result register.
// Reset: synchronous, active low; counters, targets, modes and prescalers
// clear, all counters run, divisors return to 2 and 1076.
// When o_out stalls, the result holds; one more beat waits in the input
// register and i_in.ready drops after that.
module gated_root_counter_timers (
    input logic      i_clk,
    input logic      i_rst_n,
    grc_in_if.sink   i_in,
    grc_out_if.source o_out,
    grc_cfg_if.sink  i_cfg
);
    import grc_pkg::*;

    logic      r_in_valid;
    t_grc_item r_in;
    logic      r_out_valid;
    t_data     r_rd;
    t_irq      r_irq;
    t_pix_div  r_pix_div;
    t_hs_div   r_hs_div;

    logic      w_adv;
    t_grc_cmd  w_cmd [NUM_COUNTERS];
    t_data     w_count [NUM_COUNTERS];
    t_mode     w_mode [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] w_irq_v;
    t_data     w_rd;
    t_irq      w_irq;

    assign w_adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_div <= PIX_DIV_RST;
            r_hs_div  <= HS_DIV_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PIX_DIV: r_pix_div <= i_cfg.data[PIX_W-1:0];
                CFG_HS_DIV:  r_hs_div  <= i_cfg.data[HS_W-1:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.action        <= i_in.action;
            r_in.counter_index <= i_in.counter_index;
            r_in.write_value   <= i_in.write_value;
        end
    end

    for (genvar g = 0; g < NUM_COUNTERS; g++) begin : g_cnt
        always_comb begin
            w_cmd[g].tick   = w_adv && (r_in.action == ACT_TICK);
            w_cmd[g].sel    = w_adv && (r_in.counter_index == t_idx'(g));
            w_cmd[g].action = r_in.action;
            w_cmd[g].value  = r_in.write_value;
        end

        grc_timer u_timer (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd[g]),
            .i_idx     (t_idx'(g)),
            .i_pix_div (r_pix_div),
            .i_hs_div  (r_hs_div),
            .o_count   (w_count[g]),
            .o_mode    (w_mode[g]),
            .o_irq     (w_irq_v[g])
        );
    end

    // read mux sees the state before this beat updates it
    always_comb begin
        w_rd  = '0;
        w_irq = '0;
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            if (r_in.counter_index == t_idx'(i)) begin
                if (r_in.action == ACT_RD_COUNT) begin
                    w_rd = w_count[i];
                end else if (r_in.action == ACT_RD_MODE) begin
                    w_rd = t_data'(w_mode[i]);
                end
            end
            w_irq[i] = w_irq_v[i];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd  <= w_rd;
            r_irq <= w_irq;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_data   = r_rd;
    assign o_out.irq_request = r_irq;

    `GRC_ASSERT_IMPL(a_irq_only_without_read, i_clk, i_rst_n,
        o_out.valid && (o_out.irq_request != '0), o_out.read_data == '0)
    `GRC_ASSERT_IMPL(a_full_stall_blocks_input, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !o_out.ready, !i_in.ready)
    `GRC_ASSERT_NEXT(a_mode_read_clears_flags, i_clk, i_rst_n,
        w_adv && (r_in.action == ACT_RD_MODE) && (r_in.counter_index == '0),
        !w_mode[0][MB_TGT_FLAG] && !w_mode[0][MB_OVF_FLAG] && w_mode[0][MB_IRQ_LINE])
    `GRC_ASSERT_NEXT(a_result_follows_advance, i_clk, i_rst_n,
        w_adv, r_out_valid)

endmodule
